// ----- rtl/s2c_pkg.sv -----
// s2c_pkg: shared types, constants and helper functions for the spherical to
// cartesian converter. Depends on nothing; used by the top level and the checker.
package s2c_pkg;

    // default cordic stage count, legal range 8 to 24
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    typedef logic signed [15:0] q88_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [33:0] cordic_t;

    typedef struct packed {
        logic    neg;
        cordic_t ang;
    } fold_t;

    localparam logic signed [15:0] ANGLE_LIMIT_Q13 = 16'sd25736;
    localparam cordic_t HALF_PI_Q30     = 34'sd1686629713;
    localparam cordic_t PI_Q30          = 34'sd3373259426;
    localparam cordic_t CORDIC_GAIN_Q30 = 34'sh0_26DD3B6A;

    // truncated arctangent of 2^-i in q4.30
    localparam cordic_t ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
        34'sh0_3243F6A8, 34'sh0_1DAC6705, 34'sh0_0FADBAFC, 34'sh0_07F56EA6,
        34'sh0_03FEAB76, 34'sh0_01FFD55B, 34'sh0_00FFFAAA, 34'sh0_007FFF55,
        34'sh0_003FFFEA, 34'sh0_001FFFFD, 34'sh0_000FFFFF, 34'sh0_0007FFFF,
        34'sh0_0003FFFF, 34'sh0_0001FFFF, 34'sh0_0000FFFF, 34'sh0_00007FFF,
        34'sh0_00003FFF, 34'sh0_00001FFF, 34'sh0_00000FFF, 34'sh0_000007FF,
        34'sh0_000003FF, 34'sh0_000001FF, 34'sh0_000000FF, 34'sh0_0000007F
    };

    // clamp to +-pi, widen to q4.30 and fold into +-pi/2
    function automatic fold_t fold_angle(input logic signed [15:0] ang13);
        logic signed [15:0] clamped;
        cordic_t            wide;
        fold_t              res;
        if (ang13 > ANGLE_LIMIT_Q13)
            clamped = ANGLE_LIMIT_Q13;
        else if (ang13 < -ANGLE_LIMIT_Q13)
            clamped = -ANGLE_LIMIT_Q13;
        else
            clamped = ang13;
        wide = cordic_t'(clamped) <<< 17;
        if (wide > HALF_PI_Q30)
        begin
            res.ang = wide - PI_Q30;
            res.neg = 1'b1;
        end
        else if (wide < -HALF_PI_Q30)
        begin
            res.ang = wide + PI_Q30;
            res.neg = 1'b1;
        end
        else
        begin
            res.ang = wide;
            res.neg = 1'b0;
        end
        return res;
    endfunction

    function automatic q88_t sat16(input logic signed [63:0] v);
        q88_t res;
        if (v > 64'sd32767)
            res = 16'sh7FFF;
        else if (v < -64'sd32768)
            res = 16'sh8000;
        else
            res = v[15:0];
        return res;
    endfunction

endpackage

// ----- rtl/spherical_to_cartesian_top.sv -----
// spherical_to_cartesian_top: pipelined spherical to cartesian converter with
// two parallel unrolled cordic chains and three multiply/round stages.
// Depends on s2c_pkg.
//
//  channel  | dir | tdata fields (lsb first)              | handshake
//  ---------+-----+---------------------------------------+--------------------
//  s_axis   | in  | colatitude, azimuth, radius (3 x 16)  | tvalid/tready
//  m_axis   | out | x_out, y_out, z_out (3 x 16)          | tvalid/tready
//
// one request per cycle while the output is not stalled. the register chain holds the
// fold stage, the cordic rotations, two multiply stages and the output register.
// each stage holds a valid bit and loads whenever it is empty or its successor
// loads, so bubbles close up under stall and nothing is lost or repeated. rst_n
// clears only the valid bits, asynchronously.
module spherical_to_cartesian_top
    import s2c_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // colatitude, azimuth, radius
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // x_out, y_out, z_out
);

    localparam int NS    = CORDIC_STAGES + 4;
    localparam int ST_M1 = CORDIC_STAGES + 1;
    localparam int ST_M2 = CORDIC_STAGES + 2;
    localparam int ST_OUT = CORDIC_STAGES + 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] adv;

    // per-stage load enable, rippling back from the output
    assign adv[NS-1] = ~v_reg[NS-1] | m_axis_tready;
    genvar g;
    generate
        for (g = 0; g < NS-1; g++)
        begin : g_adv
            assign adv[g] = ~v_reg[g] | adv[g+1];
        end
    endgenerate

    assign v_next = {v_reg[NS-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                    v_reg[i] <= v_next[i];
            end
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = v_reg[NS-1];

    // cordic state, index 0 is the fold stage
    cordic_t cx_reg [0:CORDIC_STAGES];
    cordic_t cy_reg [0:CORDIC_STAGES];
    cordic_t ca_reg [0:CORDIC_STAGES];
    cordic_t ax_reg [0:CORDIC_STAGES];
    cordic_t ay_reg [0:CORDIC_STAGES];
    cordic_t aa_reg [0:CORDIC_STAGES];
    logic    cneg_reg [0:CORDIC_STAGES];
    logic    aneg_reg [0:CORDIC_STAGES];
    q88_t    r_reg [0:CORDIC_STAGES];

    fold_t col_fold;
    fold_t az_fold;

    assign col_fold = fold_angle(s_axis_tdata[15:0]);
    assign az_fold  = fold_angle(s_axis_tdata[31:16]);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cx_reg[0]   <= CORDIC_GAIN_Q30;
            cy_reg[0]   <= '0;
            ca_reg[0]   <= col_fold.ang;
            cneg_reg[0] <= col_fold.neg;
            ax_reg[0]   <= CORDIC_GAIN_Q30;
            ay_reg[0]   <= '0;
            aa_reg[0]   <= az_fold.ang;
            aneg_reg[0] <= az_fold.neg;
            r_reg[0]    <= s_axis_tdata[47:32];
        end
    end

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (adv[g+1])
                begin
                    cneg_reg[g+1] <= cneg_reg[g];
                    aneg_reg[g+1] <= aneg_reg[g];
                    r_reg[g+1]    <= r_reg[g];
                    if (g >= ATAN_ENTRIES)
                    begin
                        // no constant left: stage passes through
                        cx_reg[g+1] <= cx_reg[g];
                        cy_reg[g+1] <= cy_reg[g];
                        ca_reg[g+1] <= ca_reg[g];
                        ax_reg[g+1] <= ax_reg[g];
                        ay_reg[g+1] <= ay_reg[g];
                        aa_reg[g+1] <= aa_reg[g];
                    end
                    else
                    begin
                        if (ca_reg[g] >= 0)
                        begin
                            cx_reg[g+1] <= cx_reg[g] - (cy_reg[g] >>> g);
                            cy_reg[g+1] <= cy_reg[g] + (cx_reg[g] >>> g);
                            ca_reg[g+1] <= ca_reg[g] - ATAN_Q30[g % ATAN_ENTRIES];
                        end
                        else
                        begin
                            cx_reg[g+1] <= cx_reg[g] + (cy_reg[g] >>> g);
                            cy_reg[g+1] <= cy_reg[g] - (cx_reg[g] >>> g);
                            ca_reg[g+1] <= ca_reg[g] + ATAN_Q30[g % ATAN_ENTRIES];
                        end
                        if (aa_reg[g] >= 0)
                        begin
                            ax_reg[g+1] <= ax_reg[g] - (ay_reg[g] >>> g);
                            ay_reg[g+1] <= ay_reg[g] + (ax_reg[g] >>> g);
                            aa_reg[g+1] <= aa_reg[g] - ATAN_Q30[g % ATAN_ENTRIES];
                        end
                        else
                        begin
                            ax_reg[g+1] <= ax_reg[g] + (ay_reg[g] >>> g);
                            ay_reg[g+1] <= ay_reg[g] - (ax_reg[g] >>> g);
                            aa_reg[g+1] <= aa_reg[g] + ATAN_Q30[g % ATAN_ENTRIES];
                        end
                    end
                end
            end
        end
    endgenerate

    // first multiply stage: r*sin(col) and r*cos(col), rounded to q.23
    cordic_t            col_cos_w;
    cordic_t            col_sin_w;
    cordic_t            az_cos_w;
    cordic_t            az_sin_w;
    trig_t              col_cos;
    trig_t              col_sin;
    logic signed [47:0] r_sc;
    logic signed [47:0] r_cc;
    logic signed [47:0] r_sc_rnd;
    logic signed [47:0] r_cc_rnd;

    assign col_cos_w = cneg_reg[CORDIC_STAGES] ? -cx_reg[CORDIC_STAGES] : cx_reg[CORDIC_STAGES];
    assign col_sin_w = cneg_reg[CORDIC_STAGES] ? -cy_reg[CORDIC_STAGES] : cy_reg[CORDIC_STAGES];
    assign az_cos_w  = aneg_reg[CORDIC_STAGES] ? -ax_reg[CORDIC_STAGES] : ax_reg[CORDIC_STAGES];
    assign az_sin_w  = aneg_reg[CORDIC_STAGES] ? -ay_reg[CORDIC_STAGES] : ay_reg[CORDIC_STAGES];
    assign col_cos   = col_cos_w[31:0];
    assign col_sin   = col_sin_w[31:0];

    assign r_sc     = 48'(r_reg[CORDIC_STAGES]) * 48'(col_sin);
    assign r_cc     = 48'(r_reg[CORDIC_STAGES]) * 48'(col_cos);
    assign r_sc_rnd = (r_sc + 48'sd16384) >>> 15;
    assign r_cc_rnd = (r_cc + 48'sd16384) >>> 15;

    trig_t rs_reg;
    trig_t rc_reg;
    trig_t sa_reg;
    trig_t caz_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_M1])
        begin
            rs_reg  <= r_sc_rnd[31:0];
            rc_reg  <= r_cc_rnd[31:0];
            sa_reg  <= az_sin_w[31:0];
            caz_reg <= az_cos_w[31:0];
        end
    end

    // second multiply stage: x and z products, y finished here
    logic signed [63:0] px_next;
    logic signed [63:0] pz_next;
    logic signed [32:0] y_rnd;
    logic signed [63:0] px_reg;
    logic signed [63:0] pz_reg;
    q88_t               y_reg;

    assign px_next = 64'(rs_reg) * 64'(sa_reg);
    assign pz_next = 64'(rs_reg) * 64'(caz_reg);
    assign y_rnd   = (33'(rc_reg) + 33'sd16384) >>> 15;

    always_ff @(posedge clk)
    begin
        if (adv[ST_M2])
        begin
            px_reg <= px_next;
            pz_reg <= pz_next;
            y_reg  <= sat16(64'(y_rnd));
        end
    end

    // output stage: round q.53 to q8.8 and saturate
    logic signed [63:0] x_rnd;
    logic signed [63:0] z_rnd;
    q88_t               x_out_reg;
    q88_t               y_out_reg;
    q88_t               z_out_reg;

    assign x_rnd = (px_reg + (64'sd1 <<< 44)) >>> 45;
    assign z_rnd = (pz_reg + (64'sd1 <<< 44)) >>> 45;

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            x_out_reg <= sat16(x_rnd);
            y_out_reg <= y_reg;
            z_out_reg <= sat16(z_rnd);
        end
    end

    assign m_axis_tdata = {z_out_reg, y_out_reg, x_out_reg};

endmodule

// ----- rtl/s2c_checker.sv -----
// s2c_checker: port-level assertions for spherical_to_cartesian_top, attached
// by the bind at the end of this file. Depends on s2c_pkg.
module s2c_checker
    import s2c_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata    // x_out, y_out, z_out
);

    localparam int NS = CORDIC_STAGES + 4;
    localparam int CW = $clog2(NS + 2) + 1;

    logic [CW-1:0] flight_reg;
    logic [CW-1:0] flight_next;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign out_acc = m_axis_tvalid & m_axis_tready;

    always_comb
    begin
        flight_next = flight_reg;
        if (in_acc && !out_acc)
            flight_next = flight_reg + CW'(1);
        else if (out_acc && !in_acc)
            flight_next = flight_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_next;
    end

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no result without a request in flight
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> flight_reg != '0)
        else $error("result without a pending request");

    // the pipeline never holds more than its stage count
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= CW'(NS))
        else $error("more requests in flight than stages");

    // input is refused only when the output is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused with output free");

endmodule

bind spherical_to_cartesian_top s2c_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_s2c_checker (.*);
